### rtl/core/egbr_pkg.sv
// Shared types, codes and constants for the Exp-Golomb bit reader.
package egbr_pkg;

    // Default sizing
    localparam int BUFFER_WORDS_DEF     = 3;
    localparam int MAX_PREFIX_ZEROS_DEF = 15;
    localparam int QUEUE_DEPTH          = 2;
    localparam int QPTR_W               = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W               = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_COUNT            = 32;

    // Input kind codes
    localparam logic [2:0] KIND_LOAD = 3'd0;
    localparam logic [2:0] KIND_GET  = 3'd1;
    localparam logic [2:0] KIND_SHOW = 3'd2;
    localparam logic [2:0] KIND_UE   = 3'd3;
    localparam logic [2:0] KIND_SE   = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_LONG  = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // Classified operation
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_GET,
        OP_SHOW,
        OP_UE,
        OP_SE
    } t_op;

    // Input word
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] stream_word;
        logic [5:0]  bit_count;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic signed [32:0] value;
        logic [1:0]         status;
        logic [6:0]         bits_available;
    } t_out_word;

    // Queue entry: classified operation with saturated count
    typedef struct packed {
        t_op         op;
        logic [31:0] stream_word;
        logic [5:0]  count;
    } t_op_word;

    // Queue head seen by the back end
    typedef struct packed {
        logic     valid;
        t_op_word entry;
    } t_q_head;

endpackage

### rtl/core/egbr_front.sv
// Front end: classifies incoming words and pushes them into the queue.
module egbr_front
    import egbr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_word i_in_word,
    output logic     o_in_stall,
    input  logic     i_q_full,
    output logic     o_push,
    output t_op_word o_push_word
);

    // Stall straight from queue occupancy
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // Decode kind, saturate count
    always_comb begin
        o_push_word.stream_word = i_in_word.stream_word;
        o_push_word.count       = (i_in_word.bit_count > 6'(MAX_COUNT)) ?
                                  6'(MAX_COUNT) : i_in_word.bit_count;
        unique case (i_in_word.kind)
            KIND_LOAD: o_push_word.op = OP_LOAD;
            KIND_GET:  o_push_word.op = OP_GET;
            KIND_SHOW: o_push_word.op = OP_SHOW;
            KIND_UE:   o_push_word.op = OP_UE;
            KIND_SE:   o_push_word.op = OP_SE;
            default:   o_push_word.op = OP_NONE;
        endcase
    end

`ifndef ASSERT_OFF
    // A pushed word never lands on a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_q_full)
        else $error("push while queue full");
`endif

endmodule

### rtl/core/egbr_queue.sv
// Short queue between the front end and the back end.
module egbr_queue
    import egbr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_op_word i_push_word,
    input  logic     i_pop,
    output logic     o_full,
    output t_q_head  o_head
);

    t_op_word            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    assign o_full       = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            priority if (i_push && !i_pop) r_count <= r_count + 1'b1;
            else if (!i_push && i_pop)     r_count <= r_count - 1'b1;
            else                           r_count <= r_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_push_word;
    end

`ifndef ASSERT_OFF
    // Fill count stays within depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count overflow");
    // Pop only when something is held
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head.valid)
        else $error("pop from empty queue");
`endif

endmodule

### rtl/core/egbr_back.sv
// Back end: bit buffer, read/decode datapath and output register.
module egbr_back
    import egbr_pkg::*;
#(
    parameter int BUFFER_WORDS     = BUFFER_WORDS_DEF,
    parameter int MAX_PREFIX_ZEROS = MAX_PREFIX_ZEROS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_head   i_head,
    output logic      o_pop,
    output logic      o_out_valid,
    output t_out_word o_out_word,
    input  logic      i_out_stall
);

    localparam int BUF_W   = BUFFER_WORDS * 32;
    localparam int CNT_W   = $clog2(BUF_W + 1);
    localparam int Z_W     = $clog2(MAX_PREFIX_ZEROS + 2);
    localparam int PREFIX  = MAX_PREFIX_ZEROS + 1;

    logic [BUF_W-1:0] r_buf, n_buf;
    logic [CNT_W-1:0] r_held, n_held;
    logic             r_out_valid;
    t_out_word        r_out, n_out;

    logic [31:0]      top32;
    logic [Z_W-1:0]   zeros;
    logic [5:0]       code_len;
    logic [31:0]      code;
    logic [31:0]      peek;
    logic [31:0]      mag;

    assign top32 = r_buf[BUF_W-1 -: 32];

    // Take the next word when the output register is free or draining
    assign o_pop = i_head.valid && (!r_out_valid || !i_out_stall);

    // Leading zeros over the prefix window
    always_comb begin
        zeros = Z_W'(PREFIX);
        for (int i = MAX_PREFIX_ZEROS; i >= 0; i--) begin
            if (top32[31-i]) zeros = Z_W'(i);
        end
    end

    assign code_len = 6'({zeros, 1'b1});
    assign code     = top32 >> (6'd31 - 6'({zeros, 1'b0}));
    assign mag      = code >> 1;
    assign peek     = (i_head.entry.count == '0) ? '0 :
                      top32 >> (6'(MAX_COUNT) - i_head.entry.count);

    // Execute one operation
    always_comb begin
        n_buf      = r_buf;
        n_held     = r_held;
        n_out.value  = '0;
        n_out.status = ST_OK;
        unique case (i_head.entry.op)
            OP_LOAD: begin
                if (({1'b0, r_held} + (CNT_W+1)'(32)) > (CNT_W+1)'(BUF_W)) begin
                    n_out.status = ST_FULL;
                end else begin
                    n_buf  = r_buf | ({i_head.entry.stream_word, {(BUF_W-32){1'b0}}}
                                      >> r_held);
                    n_held = r_held + CNT_W'(32);
                end
            end
            OP_GET, OP_SHOW: begin
                if (CNT_W'(i_head.entry.count) > r_held) begin
                    n_out.status = ST_UNDER;
                end else begin
                    n_out.value = 33'({1'b0, peek});
                    if (i_head.entry.op == OP_GET) begin
                        n_buf  = r_buf << i_head.entry.count;
                        n_held = r_held - CNT_W'(i_head.entry.count);
                    end
                end
            end
            OP_UE, OP_SE: begin
                priority if (zeros == Z_W'(PREFIX)) begin
                    n_out.status = (r_held >= CNT_W'(PREFIX)) ? ST_LONG : ST_UNDER;
                end else if (CNT_W'(code_len) > r_held) begin
                    n_out.status = ST_UNDER;
                end else begin
                    n_buf  = r_buf << code_len;
                    n_held = r_held - CNT_W'(code_len);
                    // codeNum = code - 1; odd code means even codeNum, negative
                    if (i_head.entry.op == OP_UE) begin
                        n_out.value = 33'({1'b0, code - 32'h1});
                    end else if (code[0] == 1'b1) begin
                        n_out.value = -$signed(33'({1'b0, mag}));
                    end else begin
                        n_out.value = 33'({1'b0, mag});
                    end
                end
            end
            default: ;
        endcase
        n_out.bits_available = 7'(n_held);
    end

    // Buffer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf  <= '0;
            r_held <= '0;
        end else if (o_pop) begin
            r_buf  <= n_buf;
            r_held <= n_held;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            r_out_valid <= o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`ifndef ASSERT_OFF
    // Fill level never exceeds capacity
    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CNT_W'(BUF_W))
        else $error("bit count above buffer size");
    // Bits below the held region stay zero
    a_low_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_buf << r_held) == '0)
        else $error("stale bits below fill level");
    // No execution while the result is stalled
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> $stable(r_held))
        else $error("buffer changed under stalled result");
    // Errors carry a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_OK) |-> (r_out.value == '0))
        else $error("nonzero value on error");
`endif

endmodule

### rtl/core/exp_golomb_bit_reader_top.sv
// Top level of the Exp-Golomb bitstream reader.
//
//   channel  direction  handshake                 word
//   in       input      i_in_valid / o_in_stall   t_in_word  (kind, stream_word, bit_count)
//   out      output     o_out_valid / i_out_stall t_out_word (value, status, bits_available)
//
// One word per cycle sustained while i_out_stall is low; a taken word is queued, then its result registered.
// The buffer shift, leading-zero detect and peek are all combinational, between queue head and back-end registers.
// A two-entry queue sits between front and back; o_in_stall rises only when it is full.
// The result register keeps taking words while its contents are consumed in the same cycle.
// Synchronous reset empties the buffer at once; no clearing pass.
module exp_golomb_bit_reader_top
    import egbr_pkg::*;
#(
    parameter int BUFFER_WORDS     = BUFFER_WORDS_DEF,
    parameter int MAX_PREFIX_ZEROS = MAX_PREFIX_ZEROS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_word  i_in_word,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_word o_out_word,
    input  logic      i_out_stall
);

    logic     q_full;
    logic     push;
    t_op_word push_word;
    logic     pop;
    t_q_head  q_head;

    egbr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_stall  (o_in_stall),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_word (push_word)
    );

    egbr_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_word (push_word),
        .i_pop       (pop),
        .o_full      (q_full),
        .o_head      (q_head)
    );

    egbr_back #(
        .BUFFER_WORDS     (BUFFER_WORDS),
        .MAX_PREFIX_ZEROS (MAX_PREFIX_ZEROS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

endmodule

### bench/exp_golomb_bit_reader_top_test.sv
// Self-checking bench for the Exp-Golomb bitstream reader top level.
`timescale 1ns / 100ps

module exp_golomb_bit_reader_top_test;
    import egbr_pkg::*;

    localparam int        BUF_BITS  = BUFFER_WORDS_DEF * 32;
    localparam int        MAX_ZEROS = MAX_PREFIX_ZEROS_DEF;
    localparam int        IDLE_PCT  = 36;
    localparam logic [2:0] KIND_LAST = 3'd7;

    // DUT connections; the inputs are known from time zero
    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;

    // Bench-side copy of the reader state
    logic [BUF_BITS-1:0] shadow_bits = '0;
    int unsigned         shadow_held = 0;

    // Results still owed by the DUT, oldest first
    t_out_word pending_results[$];
    int        mismatches  = 0;
    int        in_idle_pct  = IDLE_PCT;
    int        out_idle_pct = IDLE_PCT;

    // Bits of well-formed codes not yet packed into stream words
    bit code_bits[$];

    exp_golomb_bit_reader_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit, far above the slowest legal run
    initial begin
        #4_000_000;
        $display("exp_golomb_bit_reader_top_test NOT OK");
        $finish;
    end

    // Expected result of one word; advances the shadow state
    function automatic t_out_word predict_reader(t_in_word w);
        t_out_word          res;
        int unsigned        cnt;
        int unsigned        zeros;
        int unsigned        len;
        logic [31:0]        top;
        logic [31:0]        code;
        logic [31:0]        code_num;
        logic signed [32:0] mag;
        res = '0;
        cnt = w.bit_count;
        if (cnt > MAX_COUNT) cnt = MAX_COUNT;
        top = shadow_bits[BUF_BITS-1 -: 32];
        case (w.kind)
            KIND_LOAD: begin
                if (shadow_held + 32 > BUF_BITS) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_bits |= {w.stream_word, {(BUF_BITS-32){1'b0}}} >> shadow_held;
                    shadow_held += 32;
                end
            end
            KIND_GET, KIND_SHOW: begin
                if (cnt > shadow_held) begin
                    res.status = ST_UNDER;
                end else begin
                    // a shift by 32 yields zero, so a zero count reads nothing
                    res.value = {1'b0, top >> (32 - cnt)};
                    if (w.kind == KIND_GET) begin
                        shadow_bits <<= cnt;
                        shadow_held -= cnt;
                    end
                end
            end
            KIND_UE, KIND_SE: begin
                zeros = 0;
                while (zeros <= MAX_ZEROS && top[31-zeros] == 1'b0) zeros++;
                if (zeros > MAX_ZEROS) begin
                    res.status = (shadow_held >= zeros) ? ST_LONG : ST_UNDER;
                end else if (shadow_held < 2 * zeros + 1) begin
                    res.status = ST_UNDER;
                end else begin
                    len      = 2 * zeros + 1;
                    code     = top >> (32 - len);
                    code_num = (32'd1 << zeros) - 32'd1 + (code & ((32'd1 << zeros) - 32'd1));
                    shadow_bits <<= len;
                    shadow_held -= len;
                    if (w.kind == KIND_UE) begin
                        res.value = {1'b0, code_num};
                    end else begin
                        mag       = {1'b0, (code_num + 32'd1) >> 1};
                        res.value = code_num[0] ? mag : -mag;
                    end
                end
            end
            default: ;
        endcase
        res.bits_available = shadow_held[6:0];
        return res;
    endfunction

    function automatic t_in_word make_word(logic [2:0] kind, logic [31:0] data,
                                           logic [5:0] count);
        t_in_word w;
        w.kind        = kind;
        w.stream_word = data;
        w.bit_count   = count;
        return w;
    endfunction

    // Present one word, hold it until taken, then log its expected result
    task automatic send_word(t_in_word w);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(predict_reader(w));
    endtask

    // Result checker and random output stall
    always @(posedge i_clk) begin : check_results
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result value=%0d status=%0d avail=%0d",
                             $realtime, o_out_word.value, o_out_word.status,
                             o_out_word.bits_available);
            end else begin
                want = pending_results.pop_front();
                if (want.value !== o_out_word.value || want.status !== o_out_word.status ||
                    want.bits_available !== o_out_word.bits_available) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: exp %0d/%0d/%0d got %0d/%0d/%0d (value/status/avail)",
                                 $realtime, want.value, want.status, want.bits_available,
                                 o_out_word.value, o_out_word.status,
                                 o_out_word.bits_available);
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    // Append one random code: mostly short, some long, a few over-long prefixes
    function automatic void queue_code();
        int pick;
        int zeros;
        pick = $urandom_range(99);
        if (pick < 70)      zeros = $urandom_range(3);
        else if (pick < 95) zeros = $urandom_range(MAX_ZEROS, 4);
        else                zeros = MAX_ZEROS + 1;
        repeat (zeros) code_bits.push_back(1'b0);
        code_bits.push_back(1'b1);
        repeat (zeros) code_bits.push_back(1'($urandom_range(1)));
    endfunction

    function automatic logic [31:0] next_stream_word();
        logic [31:0] data;
        while (code_bits.size() < 32) queue_code();
        for (int i = 31; i >= 0; i--) data[i] = code_bits.pop_front();
        return data;
    endfunction

    // Reads from an empty buffer
    task automatic test_empty_reads();
        send_word(make_word(KIND_GET, 32'h0, 6'd1));
        send_word(make_word(KIND_SE, 32'h0, 6'd0));
    endtask

    // Fill to capacity, overflow, zero and saturated counts, drain by full-width reads
    task automatic test_fill_and_overflow();
        send_word(make_word(KIND_LOAD, 32'hFFFF_FFFF, 6'd0));
        send_word(make_word(KIND_LOAD, 32'h0000_0000, 6'd0));
        send_word(make_word(KIND_LOAD, 32'h1234_5678, 6'd0));
        send_word(make_word(KIND_LOAD, 32'hDEAD_BEEF, 6'd0));
        send_word(make_word(KIND_GET, 32'h0, 6'd0));
        send_word(make_word(KIND_SHOW, 32'h0, 6'd63));
        repeat (3) send_word(make_word(KIND_GET, 32'h0, 6'd32));
    endtask

    // Short ue/se codes, over-long prefix with and without enough bits
    task automatic test_short_codes();
        // 1 010 011 00100, then zeros
        send_word(make_word(KIND_LOAD, 32'hA640_0000, 6'd0));
        send_word(make_word(KIND_UE, 32'h0, 6'd0));
        send_word(make_word(KIND_SE, 32'h0, 6'd0));
        send_word(make_word(KIND_SE, 32'h0, 6'd0));
        send_word(make_word(KIND_UE, 32'h0, 6'd0));
        send_word(make_word(KIND_UE, 32'h0, 6'd0));
        send_word(make_word(KIND_GET, 32'h0, 6'd12));
        send_word(make_word(KIND_SE, 32'h0, 6'd0));
        send_word(make_word(KIND_GET, 32'h0, 6'd8));
    endtask

    // Longest legal prefix, largest ue value and most negative se value
    task automatic test_long_codes();
        send_word(make_word(KIND_LOAD, 32'h0001_FFFF, 6'd0));
        send_word(make_word(KIND_UE, 32'h0, 6'd0));
        send_word(make_word(KIND_LOAD, 32'h0001_FFFF, 6'd0));
        send_word(make_word(KIND_SE, 32'h0, 6'd0));
        send_word(make_word(KIND_SE, 32'h0, 6'd0));
        send_word(make_word(KIND_GET, 32'h0, 6'd1));
    endtask

    // Code cut short by the end of the buffered bits
    task automatic test_truncated_code();
        send_word(make_word(KIND_LOAD, 32'h0000_0001, 6'd0));
        send_word(make_word(KIND_GET, 32'h0, 6'd30));
        send_word(make_word(KIND_UE, 32'h0, 6'd0));
    endtask

    // Undefined kinds leave the state alone
    task automatic test_spare_kinds();
        for (int k = KIND_SE + 1; k <= KIND_LAST; k++)
            send_word(make_word(3'(k), $urandom, 6'($urandom_range(63))));
    endtask

    // Random traffic built mostly from well-formed code streams
    task automatic test_random_streams(int count);
        int       pick;
        t_in_word w;
        repeat (count) begin
            pick = $urandom_range(99);
            w    = make_word(KIND_LOAD, $urandom, 6'($urandom_range(63)));
            if (pick < 8) begin
                w.kind = 3'($urandom_range(KIND_LAST));
            end else if (pick < 40) begin
                w.kind = KIND_LOAD;
                if (shadow_held + 32 <= BUF_BITS) w.stream_word = next_stream_word();
            end else if (pick < 75) begin
                w.kind = $urandom_range(1) ? KIND_UE : KIND_SE;
            end else begin
                w.kind = (pick < 90) ? KIND_GET : KIND_SHOW;
                if ($urandom_range(9) != 0) w.bit_count = 6'($urandom_range(32, 1));
            end
            send_word(w);
        end
    endtask

    // Back-to-back traffic with both sides always ready
    task automatic test_steady_stream(int count);
        in_idle_pct  = 0;
        out_idle_pct = 0;
        test_random_streams(count);
        in_idle_pct  = IDLE_PCT;
        out_idle_pct = IDLE_PCT;
    endtask

    // Sender holds off until every owed result is back
    task automatic test_drain_pause();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_reads();
        test_fill_and_overflow();
        test_short_codes();
        test_long_codes();
        test_truncated_code();
        test_spare_kinds();
        test_random_streams(150);
        test_steady_stream(100);
        test_drain_pause();
        test_random_streams(200);

        // Let the pipe empty, then a few more cycles for stray results
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("exp_golomb_bit_reader_top_test OK");
        end else begin
            $display("exp_golomb_bit_reader_top_test NOT OK");
        end
        $finish;
    end

endmodule
